// File: design/cam_pkg.sv
// Shared types and constants for the connect allowlist rule matcher.
`default_nettype none
package cam_pkg;
  localparam int RULE_SLOTS = 16;
  localparam int SLOT_W = $clog2(RULE_SLOTS + 1);

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] FAM_V4 = 2'd1;
  localparam logic [1:0] FAM_V6 = 2'd2;

  localparam logic [2:0] FORM_ANY = 3'd0;
  localparam logic [2:0] FORM_V4 = 3'd1;
  localparam logic [2:0] FORM_V6 = 3'd2;
  localparam logic [2:0] FORM_LOOPBACK = 3'd3;
  localparam logic [2:0] FORM_V4_PREFIX = 3'd4;
  localparam logic [2:0] FORM_V6_PREFIX = 3'd5;

  localparam logic [31:0] MAPPED_TAG = 32'h0000ffff;

  typedef struct packed {
    logic [63:0] net_high;
    logic [63:0] net_low;
    logic [7:0]  prefix_len;
    logic [15:0] port;
    logic        all_ports;
    logic [2:0]  form;
  } rule_t;

  // Probe that travels down the chain during a check.
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [1:0]  family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port;
  } probe_t;
endpackage
`default_nettype wire

// File: design/cam_cell.sv
// One rule slot: holds a rule and tests the passing probe against it.
`default_nettype none
module cam_cell (
  input  wire              clk,
  input  wire              rst,
  input  wire              wr,
  input  cam_pkg::rule_t   rule_in,
  input  wire              active,
  input  cam_pkg::probe_t  probe_in,
  output cam_pkg::probe_t  probe_out
);
  cam_pkg::rule_t rule;
  logic [127:0] addr, net, mask;
  logic host_ok, port_ok, match;

  always_ff @(posedge clk) begin
    if (wr) rule <= rule_in;
  end

  always_comb begin
    if (probe_in.family == cam_pkg::FAM_V4)
      addr = {64'd0, cam_pkg::MAPPED_TAG, probe_in.addr_low[31:0]};
    else
      addr = {probe_in.addr_high, probe_in.addr_low};
    net = {rule.net_high, rule.net_low};
    mask = ~(128'h0) << (8'd128 - rule.prefix_len);
    host_ok = 1'b0;
    case (rule.form)
      cam_pkg::FORM_ANY: host_ok = 1'b1;
      cam_pkg::FORM_V4: host_ok = probe_in.family == cam_pkg::FAM_V4 &&
        {32'd0, probe_in.addr_low[31:0]} == rule.net_low;
      cam_pkg::FORM_V6: host_ok = probe_in.family == cam_pkg::FAM_V6 &&
        probe_in.addr_high == rule.net_high && probe_in.addr_low == rule.net_low;
      cam_pkg::FORM_LOOPBACK:
        if (probe_in.family == cam_pkg::FAM_V4)
          host_ok = probe_in.addr_low[31:24] == 8'd127;
        else if (probe_in.family == cam_pkg::FAM_V6)
          host_ok = probe_in.addr_high == 64'd0 && probe_in.addr_low == 64'd1;
      cam_pkg::FORM_V4_PREFIX, cam_pkg::FORM_V6_PREFIX:
        host_ok = (probe_in.family == cam_pkg::FAM_V4 ||
                   probe_in.family == cam_pkg::FAM_V6) &&
                  rule.prefix_len != 8'd0 && rule.prefix_len <= 8'd128 &&
                  ((addr ^ net) & mask) == 128'd0;
      default: host_ok = 1'b0;
    endcase
    port_ok = rule.all_ports || rule.port == probe_in.port;
    match = active && host_ok && port_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.hit <= probe_in.hit || (probe_in.valid && match);
    probe_out.family <= probe_in.family;
    probe_out.addr_high <= probe_in.addr_high;
    probe_out.addr_low <= probe_in.addr_low;
    probe_out.port <= probe_in.port;
  end
endmodule
`default_nettype wire

// File: design/connect_allowlist_rule_match.sv
// Top level of the connect allowlist rule matcher.
//
// Input channel s_axis_*: one transfer per item (add, check or clear).
// Output channel m_axis_*: one result transfer per item.
// Rules live in a row of RULE_SLOTS cells, one rule each, filled in order.
// Add and clear finish at acceptance; their result is registered and
// offered in the cycle after acceptance. A check probe enters cell 0 and
// moves one cell per cycle, each cell testing its own rule and ORing into
// the hit flag; the hit flag leaving the last cell is registered as the
// check result. The chain length sets the check latency.
// One item is in work at a time; s_axis_tready is low while an item is
// in work or a result waits, so a receiver stall holds the result and
// blocks new input. Reset empties the table and drops any pending result.
`default_nettype none
module connect_allowlist_rule_match (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // kind[1:0], family[3:2], address_high[67:4], address_low[131:68],
  // port[147:132], host_form[150:148], prefix_bits[158:151],
  // port_wildcard[159]
  input  wire [159:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // permitted[0], accepted[1], rules_held[6:2]
  output logic [7:0]   m_axis_tdata
);
  localparam int N = cam_pkg::RULE_SLOTS;
  localparam int IW = $clog2(N) > 0 ? $clog2(N) : 1;

  logic [1:0]   kind, family;
  logic [63:0]  a_hi, a_lo;
  logic [15:0]  port;
  logic [2:0]   form;
  logic [7:0]   plen_in;
  logic         wild;
  assign kind = s_axis_tdata[1:0];
  assign family = s_axis_tdata[3:2];
  assign a_hi = s_axis_tdata[67:4];
  assign a_lo = s_axis_tdata[131:68];
  assign port = s_axis_tdata[147:132];
  assign form = s_axis_tdata[150:148];
  assign plen_in = s_axis_tdata[158:151];
  assign wild = s_axis_tdata[159];

  logic [cam_pkg::SLOT_W-1:0] count;
  logic busy;
  logic out_valid;
  logic permitted, accepted;
  logic take;
  assign s_axis_tready = !busy && !out_valid;
  assign take = s_axis_tvalid && s_axis_tready;

  // Add validation
  cam_pkg::rule_t new_rule;
  logic add_ok;
  always_comb begin
    new_rule = '0;
    new_rule.port = wild ? 16'd0 : port;
    new_rule.all_ports = wild;
    new_rule.form = form;
    add_ok = count < cam_pkg::SLOT_W'(N);
    case (form)
      cam_pkg::FORM_ANY, cam_pkg::FORM_LOOPBACK: ;
      cam_pkg::FORM_V4: new_rule.net_low = {32'd0, a_lo[31:0]};
      cam_pkg::FORM_V6: begin
        new_rule.net_high = a_hi;
        new_rule.net_low = a_lo;
      end
      cam_pkg::FORM_V4_PREFIX: begin
        if (plen_in == 8'd0 || plen_in > 8'd32) add_ok = 1'b0;
        new_rule.net_low = {cam_pkg::MAPPED_TAG, a_lo[31:0]};
        new_rule.prefix_len = 8'd96 + plen_in;
      end
      cam_pkg::FORM_V6_PREFIX: begin
        if (plen_in == 8'd0 || plen_in > 8'd128) add_ok = 1'b0;
        if (a_hi == 64'd0 && a_lo[63:32] == cam_pkg::MAPPED_TAG && plen_in < 8'd96)
          add_ok = 1'b0;
        new_rule.net_high = a_hi;
        new_rule.net_low = a_lo;
        new_rule.prefix_len = plen_in;
      end
      default: add_ok = 1'b0;
    endcase
    if (!wild && port == 16'd0) add_ok = 1'b0;
  end

  // Cell chain
  cam_pkg::probe_t chain [N+1];
  logic [N-1:0] cell_wr, cell_active;
  always_comb begin
    chain[0].valid = take && kind == cam_pkg::KIND_CHECK;
    chain[0].hit = 1'b0;
    chain[0].family = family;
    chain[0].addr_high = a_hi;
    chain[0].addr_low = a_lo;
    chain[0].port = port;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cell_wr[i] = take && kind == cam_pkg::KIND_ADD && add_ok &&
                        count[IW-1:0] == IW'(i);
    assign cell_active[i] = count > cam_pkg::SLOT_W'(i);
    cam_cell u_cell (
      .clk(clk), .rst(rst), .wr(cell_wr[i]), .rule_in(new_rule),
      .active(cell_active[i]), .probe_in(chain[i]), .probe_out(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy <= 1'b0;
      out_valid <= 1'b0;
      permitted <= 1'b0;
      accepted <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      if (take) begin
        permitted <= 1'b0;
        accepted <= 1'b0;
        case (kind)
          cam_pkg::KIND_ADD: begin
            accepted <= add_ok;
            if (add_ok) count <= count + 1'b1;
            out_valid <= 1'b1;
          end
          cam_pkg::KIND_CHECK: busy <= 1'b1;
          cam_pkg::KIND_CLEAR: begin
            count <= '0;
            out_valid <= 1'b1;
          end
          default: out_valid <= 1'b1;
        endcase
      end
      if (chain[N].valid) begin
        busy <= 1'b0;
        permitted <= chain[N].hit;
        out_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {1'b0, count, accepted, permitted};

  assert property (@(posedge clk) disable iff (rst) count <= cam_pkg::SLOT_W'(N))
    else $error("rule count overflow");
  assert property (@(posedge clk) disable iff (rst) !(busy && out_valid))
    else $error("check busy while result pending");
  assert property (@(posedge clk) disable iff (rst) $onehot0(cell_wr))
    else $error("multiple cells written");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> out_valid && $stable(m_axis_tdata))
    else $error("result lost under stall");
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the connect allowlist rule matcher.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  // One request as the block sees it.
  typedef struct packed {
    logic        port_wildcard;
    logic [7:0]  prefix_bits;
    logic [2:0]  host_form;
    logic [15:0] port;
    logic [63:0] address_low;
    logic [63:0] address_high;
    logic [1:0]  family;
    logic [1:0]  kind;
  } request_t;

  typedef struct packed {
    logic [4:0] rules_held;
    logic       accepted;
    logic       permitted;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  connect_allowlist_rule_match u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    // kind, family, address_high, address_low, port, host_form,
    // prefix_bits, port_wildcard
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    // permitted, accepted, rules_held
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow rule table kept by the predictor.
  logic [63:0] acl_hi   [cam_pkg::RULE_SLOTS];
  logic [63:0] acl_lo   [cam_pkg::RULE_SLOTS];
  logic [7:0]  acl_len  [cam_pkg::RULE_SLOTS];
  logic [15:0] acl_port [cam_pkg::RULE_SLOTS];
  logic        acl_wild [cam_pkg::RULE_SLOTS];
  logic [2:0]  acl_form [cam_pkg::RULE_SLOTS];
  int          acl_count = 0;

  request_t pending_reqs[$];
  verdict_t expected_verdicts[$];
  int  errors = 0;
  int  cycles = 0;
  bit  stim_done = 1'b0;
  bit  hold_gate = 1'b0;     // sender waits for drain while set
  bit  drain_pause = 1'b0;   // receiver long hold-off request
  int  long_hold = 0;

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic bit prefix_hit(input logic [127:0] a, input logic [127:0] n,
                                    input int len);
    logic [127:0] mask;
    if (len == 0 || len > 128) return 1'b0;
    mask = ~128'd0 << (128 - len);
    return ((a ^ n) & mask) == '0;
  endfunction

  function automatic bit host_hit(input int i, input request_t r);
    logic [127:0] probe;
    case (acl_form[i])
      cam_pkg::FORM_ANY: return 1'b1;
      cam_pkg::FORM_V4: return r.family == cam_pkg::FAM_V4 &&
                               {32'd0, r.address_low[31:0]} == acl_lo[i];
      cam_pkg::FORM_V6: return r.family == cam_pkg::FAM_V6 && r.address_high == acl_hi[i]
                               && r.address_low == acl_lo[i];
      cam_pkg::FORM_LOOPBACK: begin
        if (r.family == cam_pkg::FAM_V4) return r.address_low[31:24] == 8'd127;
        if (r.family == cam_pkg::FAM_V6)
          return r.address_high == 0 && r.address_low == 64'd1;
        return 1'b0;
      end
      cam_pkg::FORM_V4_PREFIX, cam_pkg::FORM_V6_PREFIX: begin
        if (r.family == cam_pkg::FAM_V4)
          probe = {64'd0, cam_pkg::MAPPED_TAG, r.address_low[31:0]};
        else if (r.family == cam_pkg::FAM_V6) probe = {r.address_high, r.address_low};
        else return 1'b0;
        return prefix_hit(probe, {acl_hi[i], acl_lo[i]}, int'(acl_len[i]));
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit store_rule(input request_t r);
    logic [63:0] hi, lo;
    int plen;
    hi = '0; lo = '0; plen = 0;
    if (acl_count >= cam_pkg::RULE_SLOTS) return 1'b0;
    case (r.host_form)
      cam_pkg::FORM_ANY, cam_pkg::FORM_LOOPBACK: ;
      cam_pkg::FORM_V4: lo = {32'd0, r.address_low[31:0]};
      cam_pkg::FORM_V6: begin hi = r.address_high; lo = r.address_low; end
      cam_pkg::FORM_V4_PREFIX: begin
        if (r.prefix_bits == 0 || r.prefix_bits > 32) return 1'b0;
        lo = {cam_pkg::MAPPED_TAG, r.address_low[31:0]};
        plen = 96 + r.prefix_bits;
      end
      cam_pkg::FORM_V6_PREFIX: begin
        if (r.prefix_bits == 0 || r.prefix_bits > 128) return 1'b0;
        hi = r.address_high; lo = r.address_low;
        if (hi == 0 && lo[63:32] == cam_pkg::MAPPED_TAG && r.prefix_bits < 96)
          return 1'b0;
        plen = r.prefix_bits;
      end
      default: return 1'b0;
    endcase
    if (!r.port_wildcard && r.port == 0) return 1'b0;
    acl_hi[acl_count] = hi;
    acl_lo[acl_count] = lo;
    acl_len[acl_count] = plen[7:0];
    acl_port[acl_count] = r.port_wildcard ? 16'd0 : r.port;
    acl_wild[acl_count] = r.port_wildcard;
    acl_form[acl_count] = r.host_form;
    acl_count++;
    return 1'b1;
  endfunction

  function automatic verdict_t evaluate_request(input request_t r);
    verdict_t v;
    v = '0;
    if (r.kind == cam_pkg::KIND_ADD) v.accepted = store_rule(r);
    else if (r.kind == cam_pkg::KIND_CHECK) begin
      for (int i = 0; i < acl_count; i++)
        if ((acl_wild[i] || acl_port[i] == r.port) && host_hit(i, r)) begin
          v.permitted = 1'b1;
          break;
        end
    end else if (r.kind == cam_pkg::KIND_CLEAR) acl_count = 0;
    v.rules_held = acl_count[4:0];
    return v;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers queued items; gaps taken between transfers.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // keep offering
    end else begin
      if (s_axis_tvalid) begin
        expected_verdicts.push_back(evaluate_request(request_t'(s_axis_tdata)));
        send_gap = gap_len();
      end
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   !(hold_gate && expected_verdicts.size() > 0)) begin
        s_axis_tdata <= pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in cycles here.
  always @(posedge clk) begin
    if (long_hold > 0) begin
      long_hold--;
      if (long_hold == 0) drain_pause = 1'b0;
    end else if (drain_pause) begin
      long_hold = 300;
    end
  end

  // Monitor: random stall on the result side, held off while long_hold runs.
  int recv_gap = 0;
  always @(posedge clk) begin
    verdict_t got, want;
    cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = verdict_t'(m_axis_tdata[6:0]);
      if (m_axis_tdata[7]) report("pad", m_axis_tdata, 8'd0);
      if (expected_verdicts.size() == 0) begin
        report("unexpected", m_axis_tdata, 8'd0);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.permitted != want.permitted)
          report("permitted", {1'b0, got}, {1'b0, want});
        if (got.accepted != want.accepted)
          report("accepted", {1'b0, got}, {1'b0, want});
        if (got.rules_held != want.rules_held)
          report("rules_held", {1'b0, got}, {1'b0, want});
      end
    end
    if (long_hold > 0) begin
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      recv_gap = gap_len();
      m_axis_tready <= 1'b1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic request_t make_req(input logic [1:0] kind, input logic [1:0] fam,
      input logic [63:0] hi, input logic [63:0] lo, input logic [15:0] port,
      input logic [2:0] form, input logic [7:0] plen, input logic wild);
    request_t r;
    r.kind = kind; r.family = fam; r.address_high = hi; r.address_low = lo;
    r.port = port; r.host_form = form; r.prefix_bits = plen; r.port_wildcard = wild;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Small address pool so checks often hit stored rules.
  logic [63:0] pool_hi[4];
  logic [63:0] pool_lo[4];
  logic [15:0] pool_port[4];

  function automatic request_t random_req();
    request_t r;
    int k;
    int sel;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    sel = $urandom_range(0, 3);
    k = $urandom_range(0, 99);
    r.kind = k < 40 ? cam_pkg::KIND_ADD : k < 94 ? cam_pkg::KIND_CHECK :
             k < 98 ? cam_pkg::KIND_CLEAR : 2'd3;
    if ($urandom_range(0, 3) != 0) begin
      r.address_high = pool_hi[sel];
      r.address_low = pool_lo[sel] ^
        ($urandom_range(0, 3) == 0 ? 64'd1 << $urandom_range(0, 40) : 64'd0);
      r.port = $urandom_range(0, 4) == 0 ? 16'($urandom()) : pool_port[sel];
    end
    if ($urandom_range(0, 9) != 0) begin
      r.host_form = 3'($urandom_range(0, 5));
      r.family = $urandom_range(0, 9) == 0 ? 2'($urandom_range(0, 3))
                                           : 2'($urandom_range(1, 2));
      r.prefix_bits = r.host_form == cam_pkg::FORM_V4_PREFIX ? 8'($urandom_range(0, 33))
                                                             : 8'($urandom_range(0, 130));
    end
    if ($urandom_range(0, 2) == 0) r.port_wildcard = 1'b1;
    return r;
  endfunction

  initial begin
    request_t rq;
    for (int i = 0; i < 4; i++) begin
      pool_hi[i] = i == 0 ? 64'd0 : rand64();
      pool_lo[i] = i == 0 ? {cam_pkg::MAPPED_TAG, $urandom()} : rand64();
      pool_port[i] = 16'($urandom_range(1, 65535));
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Directed: empty-table deny, every form, bad adds, loopback, then a clear.
    pending_reqs.push_back(make_req(cam_pkg::KIND_CHECK, cam_pkg::FAM_V4, 0, 64'h7f000001,
                                    80, 0, 0, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0, 0, 0, cam_pkg::FORM_ANY, 0, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0, 0, 0, 3'd6, 0, 1));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0, 0, 0, 3'd7, 0, 1));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0, 0, 0,
                                    cam_pkg::FORM_V4_PREFIX, 0, 1));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0, 0, 0,
                                    cam_pkg::FORM_V4_PREFIX, 33, 1));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0, 0, 0,
                                    cam_pkg::FORM_V6_PREFIX, 129, 1));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0,
                                    {cam_pkg::MAPPED_TAG, 32'h0a000000},
                                    1, cam_pkg::FORM_V6_PREFIX, 95, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0,
                                    {cam_pkg::MAPPED_TAG, 32'h0a000000},
                                    1, cam_pkg::FORM_V6_PREFIX, 96, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, '1, '1, 16'hffff,
                                    cam_pkg::FORM_V4, 8'hff, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, '1, '1, 22,
                                    cam_pkg::FORM_V6, 0, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0, 0, 443,
                                    cam_pkg::FORM_LOOPBACK, 0, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0, 64'hc0a80000, 0,
                                    cam_pkg::FORM_V4_PREFIX, 32, 1));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, '1, 0, 7,
                                    cam_pkg::FORM_V6_PREFIX, 128, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, '1, 0, 7,
                                    cam_pkg::FORM_V6_PREFIX, 1, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_CHECK, 0, '1, '1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_CHECK, cam_pkg::FAM_V4, 0, '1, 16'hffff,
                                    0, 0, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_CHECK, cam_pkg::FAM_V6, '1, '1, 22,
                                    0, 0, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_CHECK, cam_pkg::FAM_V6, 0, 1, 443,
                                    0, 0, 0));
    pending_reqs.push_back(make_req(cam_pkg::KIND_CHECK, 2'd3, 0, 1, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(2'd3, 2'd3, '1, '1, '1, 3'd7, 8'hff, 1));
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back(make_req(cam_pkg::KIND_ADD, 0, 0, 0, 0,
                                      cam_pkg::FORM_ANY, 0, 1));
    pending_reqs.push_back(make_req(cam_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 540; i++) begin
      rq = random_req();
      pending_reqs.push_back(rq);
      if (i == 150) begin
        wait (pending_reqs.size() < 5);
        drain_pause = 1'b1;
      end
      if (i == 300) begin
        wait (pending_reqs.size() == 0);
        hold_gate = 1'b1;
        wait (expected_verdicts.size() == 0 && !s_axis_tvalid);
        hold_gate = 1'b0;
      end
    end
    wait (pending_reqs.size() == 0 && !s_axis_tvalid);
    wait (expected_verdicts.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
